// ----- src/btli_pkg.sv -----
// btli_pkg: shared types and codes for the breakpoint table interpolator
// no dependencies
package btli_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_FIRST  = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam int TIME_W = 32;
    localparam int VAL_W  = 16;
    localparam int FRAC_W = 16;
    localparam int ROW_W  = TIME_W + 3 * VAL_W;

    typedef struct packed {
        logic [TIME_W-1:0] tm;
        logic [VAL_W-1:0]  steer;
        logic [VAL_W-1:0]  throttle;
        logic [VAL_W-1:0]  brake;
    } row_t;

endpackage

// ----- src/breakpoint_table_linear_interpolator.sv -----
// breakpoint_table_linear_interpolator: top level, sequencer around the table ram
// depends on btli_pkg, btli_ram, btli_div
//
// usage: drive operation and the payload with start high while busy is low;
// the item is taken at that edge. append writes one breakpoint (ignored when
// the table is full), clear empties the table, a query returns one result on
// steer_out, throttle_out, brake_out and status with valid high for exactly
// one cycle. other operation codes are dropped.
// append and clear leave busy low, so the next item can follow at once.
// a query on an empty table goes straight to output; a clamping query holds
// busy to read the first entry, read the last entry, compare and output. an
// interpolating query holds busy for the clamp check, a binary search through
// the single ram read port, a read of the bracketing pair, bit-serial fraction
// division (skipped when the fraction is 0 or saturated) and the multiply, add
// and output steps. valid rises in the cycle busy drops. one item is in work
// at a time. reset empties the table at once; the ram needs no clearing pass
// since only entries below the count are read. the receiver cannot stall, so
// results are simply presented.
module breakpoint_table_linear_interpolator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  operation,
    input  logic [31:0]                 time_value,
    input  logic signed [15:0]          steer_in,
    input  logic signed [15:0]          throttle_in,
    input  logic signed [15:0]          brake_in,
    output logic                        valid,
    output logic signed [15:0]          steer_out,
    output logic signed [15:0]          throttle_out,
    output logic signed [15:0]          brake_out,
    output logic [1:0]                  status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RDL   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_SRCH  = 4'd4;
    localparam logic [3:0] S_SWAIT = 4'd5;
    localparam logic [3:0] S_RL    = 4'd6;
    localparam logic [3:0] S_RLW   = 4'd7;
    localparam logic [3:0] S_RR    = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;
    localparam logic [3:0] S_ADD   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]           state_reg;
    logic [NW-1:0]        count_reg;
    logic [NW-1:0]        lo_reg, hi_reg;
    logic [31:0]          t_reg;
    btli_pkg::row_t       first_reg, left_reg, right_reg;
    logic [1:0]           st_reg;
    logic [btli_pkg::FRAC_W-1:0] frac_reg;
    logic signed [33:0]   ps_reg, pt_reg, pb_reg;
    logic signed [15:0]   os_reg, ot_reg, ob_reg;
    logic                 valid_reg;

    logic                 we;
    logic [AW-1:0]        addr;
    btli_pkg::row_t       wrow, rrow;
    logic [NW-1:0]        mid;
    logic                 div_start, div_done;
    logic [btli_pkg::FRAC_W-1:0] div_q;
    logic [NW-1:0]        r_idx;

    btli_ram #(.WIDTH(btli_pkg::ROW_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wrow),
        .rdata (rrow)
    );

    // right entry is still on the read port when the divider starts
    btli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (t_reg - left_reg.tm),
        .den   (rrow.tm - left_reg.tm),
        .done  (div_done),
        .quot  (div_q)
    );

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    // clamp found index into 1..count-1
    assign r_idx = (lo_reg == '0) ? NW'(1) :
                   (lo_reg > count_reg - 1'b1) ? count_reg - 1'b1 : lo_reg;

    assign wrow = '{tm: time_value, steer: steer_in, throttle: throttle_in, brake: brake_in};
    assign we = (state_reg == S_IDLE) && start && (operation == btli_pkg::OP_APPEND)
                && (count_reg < NW'(TABLE_DEPTH));

    always_comb
    begin
        case (state_reg)
            S_IDLE:  addr = (start && operation == btli_pkg::OP_APPEND) ? count_reg[AW-1:0]
                                                                        : '0;
            S_RD0:   addr = AW'(count_reg - 1'b1);
            S_RDL:   addr = AW'(count_reg - 1'b1);
            S_SRCH:  addr = mid[AW-1:0];
            S_RL:    addr = AW'(r_idx - 1'b1);
            S_RLW:   addr = r_idx[AW-1:0];
            default: addr = '0;
        endcase
    end

    assign div_start = (state_reg == S_RR) &&
                       (t_reg > left_reg.tm) && (t_reg < rrow.tm);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        t_reg <= time_value;
                        case (operation)
                            btli_pkg::OP_APPEND:
                                if (we) count_reg <= count_reg + 1'b1;
                            btli_pkg::OP_CLEAR:
                                count_reg <= '0;
                            btli_pkg::OP_QUERY:
                                if (count_reg == '0)
                                begin
                                    os_reg <= '0;
                                    ot_reg <= '0;
                                    ob_reg <= '0;
                                    st_reg <= btli_pkg::ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_RD0;
                                end
                            default: ;
                        endcase
                    end
                end
                S_RD0:
                begin
                    first_reg <= rrow;
                    state_reg <= S_RDL;
                end
                S_RDL:
                    state_reg <= S_CHK;
                S_CHK:
                begin
                    // rrow holds the last entry
                    if (t_reg <= first_reg.tm)
                    begin
                        os_reg <= first_reg.steer;
                        ot_reg <= first_reg.throttle;
                        ob_reg <= first_reg.brake;
                        st_reg <= btli_pkg::ST_FIRST;
                        state_reg <= S_OUT;
                    end
                    else if (t_reg >= rrow.tm)
                    begin
                        os_reg <= rrow.steer;
                        ot_reg <= rrow.throttle;
                        ob_reg <= rrow.brake;
                        st_reg <= btli_pkg::ST_LAST;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        lo_reg <= '0;
                        hi_reg <= count_reg;
                        st_reg <= btli_pkg::ST_INTERP;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                    state_reg <= (lo_reg < hi_reg) ? S_SWAIT : S_RL;
                S_SWAIT:
                begin
                    if (rrow.tm < t_reg)
                        lo_reg <= mid + 1'b1;
                    else
                        hi_reg <= mid;
                    state_reg <= S_SRCH;
                end
                S_RL:
                    state_reg <= S_RLW;
                S_RLW:
                begin
                    left_reg <= rrow;
                    state_reg <= S_RR;
                end
                S_RR:
                begin
                    right_reg <= rrow;
                    if (t_reg <= left_reg.tm)
                    begin
                        frac_reg <= '0;
                        state_reg <= S_MUL;
                    end
                    else if (t_reg >= rrow.tm)
                    begin
                        frac_reg <= '1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                    if (div_done)
                    begin
                        frac_reg <= div_q;
                        state_reg <= S_MUL;
                    end
                S_MUL:
                begin
                    ps_reg <= $signed({1'b0, frac_reg}) *
                              (17'(signed'(right_reg.steer)) - 17'(signed'(left_reg.steer)));
                    pt_reg <= $signed({1'b0, frac_reg}) *
                              (17'(signed'(right_reg.throttle)) - 17'(signed'(left_reg.throttle)));
                    pb_reg <= $signed({1'b0, frac_reg}) *
                              (17'(signed'(right_reg.brake)) - 17'(signed'(left_reg.brake)));
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    os_reg <= 16'($signed(left_reg.steer) + 16'(ps_reg >>> 16));
                    ot_reg <= 16'($signed(left_reg.throttle) + 16'(pt_reg >>> 16));
                    ob_reg <= 16'($signed(left_reg.brake) + 16'(pb_reg >>> 16));
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign valid        = valid_reg;
    assign steer_out    = os_reg;
    assign throttle_out = ot_reg;
    assign brake_out    = ob_reg;
    assign status       = st_reg;

endmodule

// ----- src/btli_ram.sv -----
// btli_ram: generic single-port synchronous ram, registered read
// no dependencies
module btli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/btli_div.sv -----
// btli_div: restoring divider for the q0.16 fraction, one quotient bit a cycle
// depends on btli_pkg
module btli_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [btli_pkg::TIME_W-1:0]       num,
    input  logic [btli_pkg::TIME_W-1:0]       den,
    output logic                              done,
    output logic [btli_pkg::FRAC_W-1:0]       quot
);

    localparam int CW = $clog2(btli_pkg::FRAC_W + 1);

    logic [btli_pkg::TIME_W:0]         rem_reg, rem_next;
    logic [btli_pkg::TIME_W-1:0]       den_reg;
    logic [btli_pkg::FRAC_W-1:0]       q_reg;
    logic [CW-1:0]                     cnt_reg;
    logic                              run_reg;
    logic                              done_reg;
    logic [btli_pkg::TIME_W+1:0]       trial;

    // num < den, so the shifted remainder fits in TIME_W+1 bits
    always_comb
    begin
        trial = {rem_reg, 1'b0} - {2'b00, den_reg};
        rem_next = trial[btli_pkg::TIME_W+1] ? {rem_reg[btli_pkg::TIME_W-1:0], 1'b0}
                                             : trial[btli_pkg::TIME_W:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                rem_reg <= {1'b0, num};
                den_reg <= den;
            end
            else if (run_reg)
            begin
                rem_reg <= rem_next;
                q_reg   <= {q_reg[btli_pkg::FRAC_W-2:0], ~trial[btli_pkg::TIME_W+1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(btli_pkg::FRAC_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
